@@ rtl/core/ledi_pkg.sv @@
// Shared constants, codes and types of the exponential decay interpolator.
package ledi_pkg;

    localparam int DEFAULT_ENTRIES = 256;
    localparam int MAX_ENTRIES     = 4096;
    localparam int VALUE_W         = 24;
    localparam int INDEX_W         = 8;
    localparam int RESULT_W        = 17;
    localparam int FRAC_W          = 16;
    localparam int CASE_W          = 2;
    localparam int DIV_W_DEFAULT   = FRAC_W + $clog2(DEFAULT_ENTRIES + 1);
    localparam int STEP_W          = $clog2(FRAC_W + $clog2(MAX_ENTRIES + 1) + 1);

    localparam logic [RESULT_W-1:0] ONE_Q16  = RESULT_W'(65536);
    localparam logic [RESULT_W-1:0] ZERO_Q16 = '0;

    typedef enum logic
    {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    typedef enum logic [CASE_W-1:0]
    {
        CASE_INTERP = 2'd0,
        CASE_ONE    = 2'd1,
        CASE_ZERO   = 2'd2
    } result_case_t;

    typedef struct packed
    {
        logic                start;
        logic [STEP_W-1:0]   steps;
        logic [VALUE_W-1:0]  rem_init;
        logic [VALUE_W-1:0]  divisor;
    } div_cmd_t;

endpackage

@@ rtl/core/ledi_divider.sv @@
// Restoring serial divider that retires one quotient bit per cycle.
module ledi_divider #(
    parameter int DVD_W = ledi_pkg::DIV_W_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ledi_pkg::div_cmd_t  cmd,
    input  logic [DVD_W-1:0]    dividend,
    output logic                done,
    output logic [DVD_W-1:0]    quotient
);
    import ledi_pkg::*;

    logic [STEP_W-1:0]  cnt_reg;
    logic [STEP_W-1:0]  cnt_next;
    logic               done_reg;
    logic               done_next;
    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] rem_next;
    logic [VALUE_W-1:0] divisor_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DVD_W-1:0]   dvd_next;
    logic [DVD_W-1:0]   quo_reg;
    logic [DVD_W-1:0]   quo_next;
    logic [VALUE_W:0]   shifted;
    logic [VALUE_W:0]   reduced;
    logic               fits;

    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits    = shifted >= {1'b0, divisor_reg};
    assign reduced = shifted - {1'b0, divisor_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (cmd.start)
        begin
            cnt_next = cmd.steps;
            rem_next = cmd.rem_init;
            dvd_next = dividend;
            quo_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - STEP_W'(1);
            done_next = (cnt_reg == STEP_W'(1));
            rem_next  = fits ? reduced[VALUE_W-1:0] : shifted[VALUE_W-1:0];
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next  = {quo_reg[DVD_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        if (cmd.start)
        begin
            divisor_reg <= cmd.divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/lut_exp_decay_interpolator_unit.sv @@
// Top level of the breakpoint-table exp(-v) interpolator.
// A write word is stored at the edge at which it is taken, and writes can follow back to back.
// A query reads the table once per search step (up to floor(log2 N) + 1), twice more for the
// span, then runs the serial fraction divide and the scaling multiply. A zero query value
// skips straight to its result. The next word is taken only once the result has been loaded
// into the output register. Reset clears control.
module lut_exp_decay_interpolator_unit #(
    parameter int TABLE_ENTRIES = ledi_pkg::DEFAULT_ENTRIES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic [ledi_pkg::INDEX_W-1:0]       entry_index,
    input  logic [ledi_pkg::VALUE_W-1:0]       entry_value,
    input  logic [ledi_pkg::VALUE_W-1:0]       query_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ledi_pkg::RESULT_W-1:0]      decay_result,
    output logic [ledi_pkg::CASE_W-1:0]        result_case
);
    import ledi_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int DVD_W = FRAC_W + CNT_W;
    localparam int SCALE_SH = DVD_W + $clog2(TABLE_ENTRIES);
    localparam int PROD_W = 2 * DVD_W + 1;
    localparam logic [DVD_W:0] SCALE_RECIP =
        (DVD_W+1)'(((64'd1 << SCALE_SH) + 64'(TABLE_ENTRIES - 1)) / 64'(TABLE_ENTRIES));
    localparam logic [IDX_W-1:0] FIRST_MID = IDX_W'(TABLE_ENTRIES / 2);
    localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [6:0]
    {
        ST_IDLE      = 7'b0000001,
        ST_SEARCH    = 7'b0000010,
        ST_FETCH_LO  = 7'b0000100,
        ST_FETCH_HI  = 7'b0001000,
        ST_DIV_FRAC  = 7'b0010000,
        ST_SCALE     = 7'b0100000,
        ST_DONE      = 7'b1000000
    } state_t;

    logic [VALUE_W-1:0] table_mem [TABLE_ENTRIES];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_en;
    logic               in_take;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   lo_reg;
    logic [CNT_W-1:0]   lo_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [VALUE_W-1:0] v_reg;
    logic [VALUE_W-1:0] v_next;
    logic [VALUE_W-1:0] lower_reg;
    logic [VALUE_W-1:0] lower_next;
    logic [DVD_W-1:0]   num_reg;
    logic [DVD_W-1:0]   num_next;
    logic [RESULT_W-1:0] res_value_reg;
    logic [RESULT_W-1:0] res_value_next;
    result_case_t       res_case_reg;
    result_case_t       res_case_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [RESULT_W-1:0] decay_result_reg;
    logic [RESULT_W-1:0] decay_result_next;
    result_case_t       result_case_reg;
    result_case_t       result_case_next;

    logic [CNT_W-1:0]   half;
    logic [CNT_W-1:0]   mid;
    logic [CNT_W-1:0]   srch_lo;
    logic [CNT_W-1:0]   srch_cnt;
    logic [CNT_W-1:0]   scale_m;
    logic [DVD_W-1:0]   scale_num;
    logic [PROD_W-1:0]  scale_prod;
    logic               out_free;

    div_cmd_t           div_cmd;
    logic               div_done;
    logic [FRAC_W-1:0]  div_quotient;

    assign in_take  = in_valid && (state_reg == ST_IDLE);
    assign wr_en    = in_take && (req_type == REQ_WRITE)
                      && (32'(entry_index) < TABLE_ENTRIES);
    assign wr_addr  = IDX_W'(entry_index);
    assign out_free = !out_valid_reg || !out_stall;

    assign half     = cnt_reg >> 1;
    assign mid      = lo_reg + half;
    assign srch_lo  = (rd_data_reg <= v_reg) ? mid + CNT_W'(1) : lo_reg;
    assign srch_cnt = (rd_data_reg <= v_reg) ? cnt_reg - half - CNT_W'(1) : half;

    assign scale_m    = ENTRIES_C + CNT_W'(1) - lo_reg;
    assign scale_num  = {scale_m, {FRAC_W{1'b0}}} - DVD_W'(div_quotient);
    assign scale_prod = {{(DVD_W+1){1'b0}}, num_reg} * {{DVD_W{1'b0}}, SCALE_RECIP};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= entry_value;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        cnt_next       = cnt_reg;
        v_next         = v_reg;
        lower_next     = lower_reg;
        num_next       = num_reg;
        res_value_next = res_value_reg;
        res_case_next  = res_case_reg;
        rd_addr        = FIRST_MID;
        div_cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (req_type == REQ_QUERY))
                begin
                    v_next   = query_value;
                    lo_next  = '0;
                    cnt_next = ENTRIES_C;
                    if (query_value == '0)
                    begin
                        res_value_next = ONE_Q16;
                        res_case_next  = CASE_ONE;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                lo_next  = srch_lo;
                cnt_next = srch_cnt;
                if (srch_cnt != '0)
                begin
                    rd_addr = IDX_W'(srch_lo + (srch_cnt >> 1));
                end
                else
                begin
                    rd_addr = IDX_W'(srch_lo - CNT_W'(1));
                    if (srch_lo == ENTRIES_C)
                    begin
                        res_value_next = ZERO_Q16;
                        res_case_next  = CASE_ZERO;
                        state_next     = ST_DONE;
                    end
                    else if (srch_lo == '0)
                    begin
                        res_value_next = ONE_Q16;
                        res_case_next  = CASE_ONE;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_FETCH_LO;
                    end
                end
            end
            ST_FETCH_LO:
            begin
                lower_next = rd_data_reg;
                rd_addr    = IDX_W'(lo_reg);
                state_next = ST_FETCH_HI;
            end
            ST_FETCH_HI:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.steps    = STEP_W'(FRAC_W);
                div_cmd.rem_init = v_reg - lower_reg;
                div_cmd.divisor  = rd_data_reg - lower_reg;
                state_next       = ST_DIV_FRAC;
            end
            ST_DIV_FRAC:
            begin
                if (div_done)
                begin
                    num_next   = scale_num;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                res_value_next = scale_prod[SCALE_SH +: RESULT_W];
                res_case_next  = CASE_INTERP;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg && out_stall;
        decay_result_next = decay_result_reg;
        result_case_next  = result_case_reg;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_next    = 1'b1;
            decay_result_next = res_value_reg;
            result_case_next  = res_case_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg           <= lo_next;
        cnt_reg          <= cnt_next;
        v_reg            <= v_next;
        lower_reg        <= lower_next;
        num_reg          <= num_next;
        res_value_reg    <= res_value_next;
        res_case_reg     <= res_case_next;
        decay_result_reg <= decay_result_next;
        result_case_reg  <= result_case_next;
    end

    ledi_divider #(
        .DVD_W (FRAC_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend ({FRAC_W{1'b0}}),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign decay_result = decay_result_reg;
    assign result_case  = result_case_reg;

endmodule

@@ dv/lut_exp_decay_interpolator_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the breakpoint-table exp(-v) interpolator.
module lut_exp_decay_interpolator_unit_test;
    import ledi_pkg::*;

    localparam int ENTRIES      = DEFAULT_ENTRIES;
    localparam int RANDOM_WORDS = 1574;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_CYCLES  = 400;

    typedef enum int
    {
        TBL_IDEAL,
        TBL_WIDE,
        TBL_FINE,
        TBL_SHUFFLED
    } table_shape_t;

    typedef struct
    {
        req_t               kind;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] entry;
        logic [VALUE_W-1:0] arg;
        bit                 drain_first;
    } decay_request_t;

    typedef struct
    {
        logic [RESULT_W-1:0] value;
        result_case_t        kind;
    } decay_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                req_type = 1'b0;
    logic [INDEX_W-1:0]  entry_index = '0;
    logic [VALUE_W-1:0]  entry_value = '0;
    logic [VALUE_W-1:0]  query_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [RESULT_W-1:0] decay_result;
    logic [CASE_W-1:0]   result_case;

    decay_request_t      request_backlog[$];
    decay_word_t         expected_decay[$];
    logic [VALUE_W-1:0]  model_breakpoints[ENTRIES];
    logic [VALUE_W-1:0]  plan_table[ENTRIES];

    int                  total_words = 0;
    int                  offered_words = 0;
    int                  accepted_words = 0;
    int                  mismatches = 0;
    int                  send_gap = 0;
    int                  sink_gap = 0;
    bit                  hold_off = 1'b0;
    decay_request_t      word;
    decay_word_t         want;

    lut_exp_decay_interpolator_unit #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .entry_index(entry_index),
        .entry_value(entry_value),
        .query_value(query_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .decay_result(decay_result),
        .result_case(result_case)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic decay_word_t predict_decay(logic [VALUE_W-1:0] v);
        int unsigned     lo;
        int unsigned     count;
        int unsigned     half;
        int unsigned     mid;
        longint unsigned lower;
        longint unsigned upper;
        longint unsigned frac16;
        longint unsigned num;
        decay_word_t     r;
        if (v == 0)
        begin
            r.value = ONE_Q16;
            r.kind  = CASE_ONE;
            return r;
        end
        lo    = 0;
        count = ENTRIES;
        while (count > 0)
        begin
            half = count / 2;
            mid  = lo + half;
            if (model_breakpoints[mid] <= v)
            begin
                lo    = mid + 1;
                count = count - (half + 1);
            end
            else
            begin
                count = half;
            end
        end
        if (lo >= ENTRIES)
        begin
            r.value = ZERO_Q16;
            r.kind  = CASE_ZERO;
        end
        else if (lo == 0)
        begin
            r.value = ONE_Q16;
            r.kind  = CASE_ONE;
        end
        else
        begin
            lower   = model_breakpoints[lo - 1];
            upper   = model_breakpoints[lo];
            frac16  = ((longint'(v) - lower) * 65536) / (upper - lower);
            num     = longint'(ENTRIES + 1 - lo) * 65536 - frac16;
            r.value = RESULT_W'(num / ENTRIES);
            r.kind  = CASE_INTERP;
        end
        return r;
    endfunction

    function automatic bit idling_allowed();
        return accepted_words + QUIET_TAIL < total_words;
    endfunction

    task automatic queue_write(logic [INDEX_W-1:0] index, logic [VALUE_W-1:0] level, bit drain);
        decay_request_t w;
        w.kind        = REQ_WRITE;
        w.index       = index;
        w.entry       = level;
        w.arg         = VALUE_W'($urandom());
        w.drain_first = drain;
        plan_table[index] = level;
        request_backlog.push_back(w);
    endtask

    task automatic queue_query(logic [VALUE_W-1:0] v);
        decay_request_t w;
        w.kind        = REQ_QUERY;
        w.index       = INDEX_W'($urandom());
        w.entry       = VALUE_W'($urandom());
        w.arg         = v;
        w.drain_first = 1'b0;
        request_backlog.push_back(w);
    endtask

    task automatic load_table(table_shape_t shape, bit drain);
        logic [VALUE_W-1:0] level;
        int                 k;
        level = '0;
        for (k = 0; k < ENTRIES; k++)
        begin
            case (shape)
                TBL_IDEAL:
                    level = VALUE_W'($rtoi(-$ln(real'(ENTRIES - k) / real'(ENTRIES))
                                           * 524288.0 + 0.5));
                TBL_WIDE:
                    level = (k == 0) ? '0 : level + VALUE_W'($urandom_range(1, 65000));
                TBL_FINE:
                    level = (k == 0) ? VALUE_W'($urandom_range(1, 4000))
                                     : level + VALUE_W'($urandom_range(1, 16));
                default:
                    level = (k % 4 == 3) ? level : VALUE_W'($urandom_range(0, 24'hFFFFFF));
            endcase
            queue_write(INDEX_W'(k), level, drain && k == 0);
        end
    endtask

    // The sender holds a word until it is taken and pauses before a word marked to wait.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || accepted_words == offered_words))
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (request_backlog.size() == 0 ||
                     (request_backlog[0].drain_first && expected_decay.size() != 0))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                word = request_backlog.pop_front();
                req_type    <= word.kind;
                entry_index <= word.index;
                entry_value <= word.entry;
                query_value <= word.arg;
                in_valid    <= 1'b1;
                offered_words = offered_words + 1;
                if (idling_allowed() && $urandom_range(0, 11) == 0)
                    send_gap = $urandom_range(1, 11);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_gap > 0)
                sink_gap = sink_gap - 1;
            else if (idling_allowed() && $urandom_range(0, 9) == 0)
                sink_gap = $urandom_range(1, 11);
            out_stall <= hold_off || sink_gap > 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            accepted_words = accepted_words + 1;
            if (req_type == REQ_WRITE)
            begin
                if (int'(entry_index) < ENTRIES)
                    model_breakpoints[entry_index] = entry_value;
            end
            else
            begin
                expected_decay.push_back(predict_decay(query_value));
            end
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_decay.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: value %0d case %0d", decay_result, result_case);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = expected_decay.pop_front();
                if (decay_result !== want.value || result_case !== want.kind)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected value %0d case %0d, got value %0d case %0d",
                                 want.value, want.kind, decay_result, result_case);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    initial
    begin
        wait (accepted_words >= 600);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int                 directed_words;
        int                 phase;
        int                 n;
        int                 k;
        int                 sel;
        logic [VALUE_W-1:0] arg;

        load_table(TBL_IDEAL, 1'b0);
        queue_query('0);
        queue_query(24'd1);
        queue_query(plan_table[1] - 24'd1);
        queue_query(plan_table[1]);
        queue_query(plan_table[1] + 24'd1);
        queue_query((plan_table[10] + plan_table[11]) / 2);
        queue_query(plan_table[128]);
        queue_query(plan_table[128] + 24'd1);
        queue_query(plan_table[254]);
        queue_query(plan_table[ENTRIES-1] - 24'd1);
        queue_query(plan_table[ENTRIES-1]);
        queue_query(plan_table[ENTRIES-1] + 24'd1);
        queue_query(24'h800000);
        queue_query(24'hFFFFFF);
        queue_write('0, 24'd100, 1'b0);
        queue_query(24'd50);
        queue_query(24'd99);
        queue_query(24'd100);
        queue_write('0, '0, 1'b0);
        queue_query(24'd1);
        directed_words = request_backlog.size();

        phase = 1;
        while (request_backlog.size() < directed_words + RANDOM_WORDS)
        begin
            load_table(table_shape_t'(phase % 4), 1'b1);
            for (n = 0; n < 350 && request_backlog.size() < directed_words + RANDOM_WORDS; n++)
            begin
                sel = $urandom_range(0, 99);
                k   = $urandom_range(0, ENTRIES - 1);
                if (sel < 3)
                begin
                    queue_write(INDEX_W'(k), VALUE_W'($urandom()), 1'b0);
                end
                else if (sel < 7)
                begin
                    if (k > 0 && k < ENTRIES - 1 && plan_table[k+1] > plan_table[k-1] + 1)
                        arg = VALUE_W'($urandom_range(plan_table[k-1] + 1, plan_table[k+1] - 1));
                    else
                        arg = plan_table[k];
                    queue_write(INDEX_W'(k), arg, 1'b0);
                end
                else
                begin
                    if (sel < 12)
                        arg = '0;
                    else if (sel < 17)
                        arg = '1;
                    else if (sel < 40)
                        arg = plan_table[k];
                    else if (sel < 50)
                        arg = plan_table[k] + ($urandom_range(0, 1) ? 24'd1 : 24'hFFFFFF);
                    else if (sel < 85)
                        arg = VALUE_W'($urandom_range(plan_table[0], plan_table[ENTRIES-1]));
                    else
                        arg = VALUE_W'($urandom_range(0, 24'hFFFFFF));
                    queue_query(arg);
                end
            end
            phase = phase + 1;
        end
        total_words = request_backlog.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_words < total_words || expected_decay.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (mismatches == 0 && expected_decay.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ledi_pkg.sv
rtl/core/ledi_divider.sv
rtl/core/lut_exp_decay_interpolator_unit.sv
dv/lut_exp_decay_interpolator_unit_test.sv
